// ----- rtl/sdspi_pkg.sv -----
package sdspi_pkg;

    localparam int WRITE_BLOCK_BYTES = 512;
    localparam int WR_CNT_W = $clog2(WRITE_BLOCK_BYTES + 1);
    // byte counter serves both the 10-bit read length and the write count
    localparam int BCNT_W = (WR_CNT_W > 10) ? WR_CNT_W : 10;

    localparam logic [2:0] ACT_CMD   = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_CARD  = 3'd3;
    localparam logic [2:0] ACT_DATA  = 3'd4;

    localparam logic [1:0] REG_BUSY_LIMIT  = 2'd0;
    localparam logic [1:0] REG_TOKEN_LIMIT = 2'd1;
    localparam logic [1:0] REG_RESP_TRIES  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_TOKEN    = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE, PH_CMD_READY, PH_CMD_FRAME, PH_CMD_STUFF, PH_CMD_RESP,
        PH_WR_READY, PH_WR_TOKEN, PH_WR_NEED, PH_WR_DATA, PH_WR_CRC1,
        PH_WR_CRC2, PH_WR_RESP, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC1,
        PH_RD_CRC2
    } phase_t;

    typedef enum logic [2:0] {
        K_IGNORE, K_CMD, K_READ, K_WRITE, K_CARD, K_DATA
    } kind_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  command;
        logic [31:0] argument;
        logic [7:0]  token;
        logic [9:0]  read_length;
        logic [7:0]  byte_value;
    } in_item_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       chip_select;
        logic       need_data;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] response;
    } out_item_t;

    // classified word from front to back
    typedef struct packed {
        kind_t    kind;
        in_item_t item;
    } job_t;

    localparam int QDEPTH = 2;

endpackage

// ----- rtl/sdspi_front.sv -----
module sdspi_front
    import sdspi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_item_t in_data,
    input  logic     in_valid,
    output logic     in_ready,
    output job_t     job,
    output logic     job_valid,
    input  logic     job_ready
);

    // two-entry queue; classification on entry
    job_t        q_reg [QDEPTH];
    logic [1:0]  cnt_reg, cnt_next;
    logic        rd_reg, rd_next, wr_reg, wr_next;
    kind_t       kind;
    logic        push, pop;

    always_comb
    begin
        case (in_data.action)
            ACT_CMD:   kind = K_CMD;
            ACT_READ:  kind = K_READ;
            ACT_WRITE: kind = K_WRITE;
            ACT_CARD:  kind = K_CARD;
            ACT_DATA:  kind = K_DATA;
            default:   kind = K_IGNORE;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'(QDEPTH));
    assign push      = in_valid && in_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= '{kind: kind, item: in_data};
        end
    end

endmodule

// ----- rtl/sdspi_back.sv -----
module sdspi_back
    import sdspi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        job,
    input  logic        job_valid,
    output logic        job_ready,
    input  logic [23:0] busy_limit,
    input  logic [23:0] token_limit,
    input  logic [7:0]  resp_tries,
    output out_item_t   out_data,
    output logic        out_valid,
    input  logic        out_ready
);

    phase_t              phase_reg, phase_next;
    logic [23:0]         wait_reg, wait_next;
    logic [BCNT_W-1:0]   bcnt_reg, bcnt_next;
    logic [7:0]          cmd_reg, cmd_next;
    logic [31:0]         arg_reg, arg_next;
    logic [7:0]          tok_reg, tok_next;
    logic                sel_reg, sel_next;
    logic                pre_reg, pre_next;
    logic                ov_reg;
    out_item_t           o_reg, r;
    logic                step;
    logic [6:0]          idx;
    logic [7:0]          b;
    logic [BCNT_W-1:0]   binc;
    logic [31:0]         farg;
    in_item_t            it;

    assign it        = job.item;
    assign job_ready = !ov_reg || out_ready;
    assign step      = job_valid && job_ready;
    assign out_valid = ov_reg;
    assign out_data  = o_reg;
    assign idx       = pre_reg ? 7'd55 : cmd_reg[6:0];
    assign b         = it.byte_value;
    assign binc      = bcnt_reg + BCNT_W'(1);
    assign farg      = pre_reg ? 32'd0 : arg_reg;

    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        bcnt_next  = bcnt_reg;
        cmd_next   = cmd_reg;
        arg_next   = arg_reg;
        tok_next   = tok_reg;
        sel_next   = sel_reg;
        pre_next   = pre_reg;
        r          = '0;
        if (job.kind == K_CMD && phase_reg == PH_IDLE)
        begin
            cmd_next     = it.command;
            arg_next     = it.argument;
            pre_next     = it.command[7];
            sel_next     = 1'b1;
            wait_next    = busy_limit;
            phase_next   = PH_CMD_READY;
            r.send_valid = 1'b1; r.send_byte = 8'hFF;
        end
        else if (job.kind == K_READ && phase_reg == PH_IDLE)
        begin
            bcnt_next    = BCNT_W'(it.read_length);
            wait_next    = token_limit;
            phase_next   = PH_RD_TOKEN;
            r.send_valid = 1'b1; r.send_byte = 8'hFF;
        end
        else if (job.kind == K_WRITE && phase_reg == PH_IDLE)
        begin
            tok_next     = it.token;
            wait_next    = busy_limit;
            phase_next   = PH_WR_READY;
            r.send_valid = 1'b1; r.send_byte = 8'hFF;
        end
        else if (job.kind == K_DATA && phase_reg == PH_WR_NEED)
        begin
            phase_next   = PH_WR_DATA;
            r.send_valid = 1'b1; r.send_byte = b;
        end
        else if (job.kind == K_CARD && phase_reg != PH_IDLE && phase_reg != PH_WR_NEED)
        begin
            case (phase_reg)
                PH_CMD_READY:
                begin
                    if (b == 8'hFF)
                    begin
                        bcnt_next = '0; phase_next = PH_CMD_FRAME;
                        r.send_valid = 1'b1; r.send_byte = {1'b0, 7'h40 | idx};
                    end
                    else if (wait_reg > 24'd1)
                    begin
                        wait_next = wait_reg - 24'd1;
                        r.send_valid = 1'b1; r.send_byte = 8'hFF;
                    end
                    else
                    begin
                        sel_next = 1'b0; pre_next = 1'b0;
                        r.response = 8'hFF; r.done_res = 1'b1; r.status = ST_BUSY;
                        phase_next = PH_IDLE;
                    end
                end
                PH_CMD_FRAME:
                begin
                    bcnt_next = binc;
                    r.send_valid = 1'b1;
                    case (binc[2:0])
                        3'd1:    r.send_byte = farg[31:24];
                        3'd2:    r.send_byte = farg[23:16];
                        3'd3:    r.send_byte = farg[15:8];
                        3'd4:    r.send_byte = farg[7:0];
                        3'd5:    r.send_byte = (idx == 7'd0) ? 8'h95 :
                                               (idx == 7'd8) ? 8'h87 : 8'h01;
                        default:
                        begin
                            r.send_byte = 8'hFF;
                            if (idx == 7'd12) phase_next = PH_CMD_STUFF;
                            else
                            begin
                                phase_next = PH_CMD_RESP;
                                wait_next  = {16'd0, resp_tries};
                            end
                        end
                    endcase
                end
                PH_CMD_STUFF:
                begin
                    phase_next = PH_CMD_RESP; wait_next = {16'd0, resp_tries};
                    r.send_valid = 1'b1; r.send_byte = 8'hFF;
                end
                PH_CMD_RESP:
                begin
                    if (b[7] && wait_reg > 24'd1)
                    begin
                        wait_next = wait_reg - 24'd1;
                        r.send_valid = 1'b1; r.send_byte = 8'hFF;
                    end
                    else if (pre_reg && b <= 8'd1)
                    begin
                        // prefix accepted: select again for the real command
                        pre_next = 1'b0; sel_next = 1'b1;
                        wait_next = busy_limit; phase_next = PH_CMD_READY;
                        r.send_valid = 1'b1; r.send_byte = 8'hFF;
                    end
                    else
                    begin
                        pre_next = 1'b0; r.response = b;
                        r.done_res = 1'b1; r.status = ST_OK; phase_next = PH_IDLE;
                    end
                end
                PH_WR_READY:
                begin
                    if (b == 8'hFF)
                    begin
                        phase_next = PH_WR_TOKEN;
                        r.send_valid = 1'b1; r.send_byte = tok_reg;
                    end
                    else if (wait_reg > 24'd1)
                    begin
                        wait_next = wait_reg - 24'd1;
                        r.send_valid = 1'b1; r.send_byte = 8'hFF;
                    end
                    else
                    begin
                        r.done_res = 1'b1; r.status = ST_BUSY; phase_next = PH_IDLE;
                    end
                end
                PH_WR_TOKEN:
                begin
                    if (tok_reg == 8'hFD)
                    begin
                        r.done_res = 1'b1; phase_next = PH_IDLE;
                    end
                    else
                    begin
                        bcnt_next = '0; phase_next = PH_WR_NEED; r.need_data = 1'b1;
                    end
                end
                PH_WR_DATA:
                begin
                    bcnt_next = binc;
                    if (32'(binc) < 32'(WRITE_BLOCK_BYTES))
                    begin
                        phase_next = PH_WR_NEED; r.need_data = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_WR_CRC1;
                        r.send_valid = 1'b1; r.send_byte = 8'hFF;
                    end
                end
                PH_WR_CRC1:
                begin
                    phase_next = PH_WR_CRC2; r.send_valid = 1'b1; r.send_byte = 8'hFF;
                end
                PH_WR_CRC2:
                begin
                    phase_next = PH_WR_RESP; r.send_valid = 1'b1; r.send_byte = 8'hFF;
                end
                PH_WR_RESP:
                begin
                    r.done_res = 1'b1; phase_next = PH_IDLE;
                    r.status = (b[4:0] == 5'h05) ? ST_OK : ST_REJECTED;
                end
                PH_RD_TOKEN:
                begin
                    if (b == 8'hFF && wait_reg > 24'd1)
                    begin
                        wait_next = wait_reg - 24'd1;
                        r.send_valid = 1'b1; r.send_byte = 8'hFF;
                    end
                    else if (b == 8'hFE)
                    begin
                        phase_next = PH_RD_DATA;
                        r.send_valid = 1'b1; r.send_byte = 8'hFF;
                    end
                    else
                    begin
                        r.done_res = 1'b1; r.status = ST_TOKEN; phase_next = PH_IDLE;
                    end
                end
                PH_RD_DATA:
                begin
                    r.read_valid = 1'b1; r.read_byte = b;
                    if (bcnt_reg == BCNT_W'(1))
                    begin
                        r.read_last = 1'b1; phase_next = PH_RD_CRC1;
                    end
                    // wrap within the 10-bit read length
                    else bcnt_next = BCNT_W'(bcnt_reg[9:0] - 10'd1);
                    r.send_valid = 1'b1; r.send_byte = 8'hFF;
                end
                PH_RD_CRC1:
                begin
                    phase_next = PH_RD_CRC2; r.send_valid = 1'b1; r.send_byte = 8'hFF;
                end
                PH_RD_CRC2:
                begin
                    r.done_res = 1'b1; phase_next = PH_IDLE;
                end
                default: ;
            endcase
        end
        r.chip_select = sel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wait_reg  <= '0;
            bcnt_reg  <= '0;
            cmd_reg   <= '0;
            arg_reg   <= '0;
            tok_reg   <= '0;
            sel_reg   <= 1'b0;
            pre_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                wait_reg  <= wait_next;
                bcnt_reg  <= bcnt_next;
                cmd_reg   <= cmd_next;
                arg_reg   <= arg_next;
                tok_reg   <= tok_next;
                sel_reg   <= sel_next;
                pre_reg   <= pre_next;
            end
            if (step) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            o_reg <= r;
        end
    end

endmodule

// ----- rtl/sd_spi_command_and_block_engine_top.sv -----
// SD card SPI-mode host engine above an external byte shifter.
// in channel (in_data/in_valid/in_ready): one word per request, card byte
// or write data byte. out channel (out_data/out_valid/out_ready): exactly
// one result word per input word, in order. cfg channel writes the busy
// wait limit (index 0), token wait limit (1) and response attempts (2);
// write it only while idle.
// A word accepted on the in port is written into the two-entry input
// queue; the protocol engine then steps on it and loads its result
// register, which drives the out port.
// Throughput: one word per cycle while out_ready stays high, set by the
// phase update of the engine, which steps once per word.
// When out_ready is low the result register holds; the queue then fills
// and in_ready drops after two further words.
// Reset: phase idle, chip select released, queue empty, limits at
// 21000, 4200 and 10.
module sd_spi_command_and_block_engine_top
    import sdspi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    in_data,
    input  logic        in_valid,
    output logic        in_ready,
    output out_item_t   out_data,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    job_t        job;
    logic        job_valid, job_ready;
    logic [23:0] busy_reg, token_reg;
    logic [7:0]  tries_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 24'd21000;
            token_reg <= 24'd4200;
            tries_reg <= 8'd10;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BUSY_LIMIT:  busy_reg  <= cfg_data;
                REG_TOKEN_LIMIT: token_reg <= cfg_data;
                REG_RESP_TRIES:  tries_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    sdspi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    sdspi_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .busy_limit  (busy_reg),
        .token_limit (token_reg),
        .resp_tries  (tries_reg),
        .out_data    (out_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

`ifndef SYNTHESIS
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.done_res |-> out_data.status == ST_OK)
        else $error("status without done");
    a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.read_valid |-> out_data.read_byte == 8'd0
        && !out_data.read_last)
        else $error("read fields without read_valid");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
`endif

endmodule
